### rtl/bbd_pkg.sv
// Shared types and constants for the bilinear Bayer demosaic block.
// Holds pixel, window, job and configuration types; no dependencies.
package bbd_pkg;

  localparam int PIX_W      = 8;
  localparam int COORD_W    = 10;
  localparam int DIM_W      = 11;
  localparam int PADDR_W    = 4;
  localparam int APB_DATA_W = 32;

  localparam int MAX_COLS_DEF = 1024;
  localparam int MAX_ROWS_DEF = 1024;

  // Job FIFO depth, a power of two
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Register indexes (byte address is 4 * index)
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_GRAY_MODE    = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_BLUE_FIRST   = 2'd3;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd320;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd240;
  localparam logic             GRAY_RESET   = 1'b0;
  localparam logic             BLUE_RESET   = 1'b1;

  // Output spots of one input sample; bit 1 = last row, bit 0 = last column
  localparam int SPOT_COUNT = 4;
  localparam logic [1:0] SPOT_PREV_ROW_PREV_COL = 2'd0;
  localparam logic [1:0] SPOT_PREV_ROW_LAST_COL = 2'd1;
  localparam logic [1:0] SPOT_LAST_ROW_PREV_COL = 2'd2;
  localparam logic [1:0] SPOT_LAST_ROW_LAST_COL = 2'd3;

  typedef logic [PIX_W-1:0] pix_t;

  // 3x3 neighborhood: [row r-2, r-1, r][col c-2, c-1, c]
  typedef logic [2:0][2:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
    logic             gray_mode;
    logic             blue_first;
  } cfg_t;

  typedef struct packed {
    win_t                  win;
    logic [COORD_W-1:0]    row;
    logic [COORD_W-1:0]    col;
    logic                  row_one;
    logic                  col_one;
    logic [SPOT_COUNT-1:0] spots;
  } job_t;

endpackage

### rtl/bbd_pixel_if.sv
// Raw sample channel: valid/ready handshake carrying one Bayer sample.
// Depends on bbd_pkg.
interface bbd_pixel_if;
  import bbd_pkg::*;

  logic valid;
  logic ready;
  pix_t raw_pixel;

  modport source(output valid, output raw_pixel, input ready);
  modport sink(input valid, input raw_pixel, output ready);
endinterface

### rtl/bbd_result_if.sv
// Result channel: valid/ready handshake carrying one demosaiced pixel.
// Depends on bbd_pkg.
interface bbd_result_if;
  import bbd_pkg::*;

  logic               valid;
  logic               ready;
  pix_t               first_byte;
  pix_t               second_byte;
  pix_t               third_byte;
  logic [COORD_W-1:0] pixel_row;
  logic [COORD_W-1:0] pixel_column;
  logic               last_in_run;
  logic               frame_end;

  modport source(output valid, output first_byte, output second_byte, output third_byte,
                 output pixel_row, output pixel_column, output last_in_run,
                 output frame_end, input ready);
  modport sink(input valid, input first_byte, input second_byte, input third_byte,
               input pixel_row, input pixel_column, input last_in_run,
               input frame_end, output ready);
endinterface

### rtl/bbd_front.sv
// Front end: accepts raw samples, tracks raster position, keeps the two line
// stores and the 3x3 window, and pushes one job per sample that emits pixels.
// Depends on bbd_pkg and bbd_pixel_if.
module bbd_front #(
  parameter int MAX_COLS = bbd_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = bbd_pkg::MAX_ROWS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  bbd_pkg::cfg_t cfg,
  input  logic          restart,
  bbd_pixel_if.sink     sample,
  input  logic          q_full,
  output logic          q_push,
  output bbd_pkg::job_t q_job
);
  import bbd_pkg::*;

  localparam int CW = $clog2(MAX_COLS);
  localparam int RW = $clog2(MAX_ROWS);

  logic [31:0]   fw_ext, fh_ext;
  logic [CW-1:0] col_last, col, col_next;
  logic [RW-1:0] row_last, row, row_next;
  logic          accept, advance;

  logic                  s1_valid;
  pix_t                  s1_px;
  logic [CW-1:0]         s1_col;
  logic [RW-1:0]         s1_row;
  logic                  s1_row_one, s1_col_one;
  logic [SPOT_COUNT-1:0] s1_spots, spots_in;

  logic                 wr_en;
  logic [2*PIX_W-1:0]   line_mem [MAX_COLS];
  logic [2*PIX_W-1:0]   rd_line;

  win_t win, win_next;

  // Clamp geometry to the supported range
  assign fw_ext = 32'(cfg.frame_width);
  assign fh_ext = 32'(cfg.frame_height);

  always_comb begin
    if (fw_ext < 32'd2) begin
      col_last = CW'(1);
    end else if (fw_ext > 32'(MAX_COLS)) begin
      col_last = CW'(MAX_COLS - 1);
    end else begin
      col_last = CW'(fw_ext - 32'd1);
    end
    if (fh_ext < 32'd2) begin
      row_last = RW'(1);
    end else if (fh_ext > 32'(MAX_ROWS)) begin
      row_last = RW'(MAX_ROWS - 1);
    end else begin
      row_last = RW'(fh_ext - 32'd1);
    end
  end

  // Handshake: stage 1 drains into the FIFO, or drops when nothing is emitted
  assign advance      = s1_valid && (!q_full || s1_spots == '0);
  assign sample.ready = !s1_valid || advance;
  assign accept       = sample.valid && sample.ready;
  assign q_push       = advance && (s1_spots != '0);

  // Advance raster position
  always_comb begin
    col_next = col;
    row_next = row;
    if (accept) begin
      if (col == col_last) begin
        col_next = '0;
        row_next = (row == row_last) ? '0 : row + 1'b1;
      end else begin
        col_next = col + 1'b1;
      end
    end
  end

  // Classify which pixels this sample completes
  always_comb begin
    spots_in = '0;
    spots_in[SPOT_PREV_ROW_PREV_COL] = (row != '0) && (col != '0);
    spots_in[SPOT_PREV_ROW_LAST_COL] = (row != '0) && (col == col_last);
    spots_in[SPOT_LAST_ROW_PREV_COL] = (row == row_last) && (col != '0);
    spots_in[SPOT_LAST_ROW_LAST_COL] = (row == row_last) && (col == col_last);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      row      <= '0;
      col      <= '0;
      s1_valid <= 1'b0;
      wr_en    <= 1'b0;
      win      <= '0;
    end else begin
      wr_en <= accept;
      if (restart) begin
        row      <= '0;
        col      <= '0;
        s1_valid <= 1'b0;
        win      <= '0;
      end else begin
        row <= row_next;
        col <= col_next;
        if (accept) begin
          s1_valid <= 1'b1;
        end else if (advance) begin
          s1_valid <= 1'b0;
        end
        if (advance) begin
          win <= win_next;
        end
      end
    end
  end

  // Capture the sample and its position
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px      <= sample.raw_pixel;
      s1_col     <= col;
      s1_row     <= row;
      s1_spots   <= spots_in;
      s1_row_one <= (row == RW'(1));
      s1_col_one <= (col == CW'(1));
    end
  end

  // Line stores: {older, newer}; read on accept, write back in the following cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_line <= line_mem[col];
    end
    if (wr_en) begin
      line_mem[s1_col] <= {rd_line[PIX_W-1:0], s1_px};
    end
  end

  // Shift the window one column and load the new column
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_next[i][0] = win[i][1];
      win_next[i][1] = win[i][2];
    end
    win_next[0][2] = rd_line[2*PIX_W-1:PIX_W];
    win_next[1][2] = rd_line[PIX_W-1:0];
    win_next[2][2] = s1_px;
  end

  always_comb begin
    q_job.win     = win_next;
    q_job.row     = COORD_W'(s1_row);
    q_job.col     = COORD_W'(s1_col);
    q_job.row_one = s1_row_one;
    q_job.col_one = s1_col_one;
    q_job.spots   = s1_spots;
  end

  // The frame corner completes all four spots of its sample
  a_corner_spots: assert property (@(posedge clk) disable iff (rst)
    q_push && q_job.spots[SPOT_LAST_ROW_LAST_COL] |-> (&q_job.spots))
    else $error("corner sample without all spots");

  // Raster position stays inside the active frame
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (col <= col_last) && (row <= row_last))
    else $error("raster position outside frame");

endmodule

### rtl/bbd_queue.sv
// Short job FIFO between the front end and the back end.
// Depends on bbd_pkg.
module bbd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bbd_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output bbd_pkg::job_t head,
  output logic          empty
);
  import bbd_pkg::*;

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("job FIFO overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("job FIFO underflow");

endmodule

### rtl/bbd_back.sv
// Back end: walks the head job's pending spots, interpolates one pixel per
// cycle unless stalled, then formats gray or colour in the output register.
// Depends on bbd_pkg and bbd_result_if.
module bbd_back (
  input  logic          clk,
  input  logic          rst,
  input  bbd_pkg::cfg_t cfg,
  input  logic          q_empty,
  input  bbd_pkg::job_t q_head,
  output logic          q_pop,
  bbd_result_if.source  result
);
  import bbd_pkg::*;

  // Window row/column positions
  localparam logic [1:0] POS_FAR  = 2'd0;
  localparam logic [1:0] POS_MID  = 2'd1;
  localparam logic [1:0] POS_NEAR = 2'd2;

  // Divide by three: floor(s * 683 / 2048) is exact for s below 768
  localparam int SUM_W      = PIX_W + 2;
  localparam int PROD_W     = 2 * SUM_W;
  localparam int GRAY_RECIP = 683;
  localparam int GRAY_SHIFT = 11;

  logic [SPOT_COUNT-1:0] served, remaining, pick_mask;
  logic [1:0]            spot;
  logic                  last, issue;

  logic [1:0] rc, cc, up, dn, lf, rt;
  logic       odd_r, odd_c;
  pix_t       ctr, hl, hr, vu, vd, d_ul, d_ur, d_dl, d_dr;
  logic [PIX_W:0]   hor, ver;
  logic [PIX_W+1:0] dia, hv;
  pix_t       red, grn, blu;

  logic               b1_valid;
  pix_t               b1_r, b1_g, b1_b;
  logic [COORD_W-1:0] b1_row, b1_col;
  logic               b1_last, b1_end;

  logic               out_valid, out_load;
  pix_t               out_first, out_second, out_third;
  logic [COORD_W-1:0] out_row, out_col;
  logic               out_last, out_end;

  logic [SUM_W-1:0]  gray_sum;
  logic [PROD_W-1:0] gray_prod;

  // Pick the next pending spot of the head job
  assign remaining = q_head.spots & ~served;

  always_comb begin
    priority if (remaining[SPOT_PREV_ROW_PREV_COL]) begin
      spot = SPOT_PREV_ROW_PREV_COL;
    end else if (remaining[SPOT_PREV_ROW_LAST_COL]) begin
      spot = SPOT_PREV_ROW_LAST_COL;
    end else if (remaining[SPOT_LAST_ROW_PREV_COL]) begin
      spot = SPOT_LAST_ROW_PREV_COL;
    end else begin
      spot = SPOT_LAST_ROW_LAST_COL;
    end
  end

  assign pick_mask = SPOT_COUNT'(1) << spot;
  assign last      = (remaining & ~pick_mask) == '0;
  assign out_load  = b1_valid && (!out_valid || result.ready);
  assign issue     = !q_empty && (!b1_valid || out_load);
  assign q_pop     = issue && last;

  // Track served spots; clear when the job leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      served <= '0;
    end else if (issue) begin
      served <= last ? '0 : (served | pick_mask);
    end
  end

  // Neighbor positions with mirror reflection at the frame edges
  always_comb begin
    rc = spot[1] ? POS_NEAR : POS_MID;
    cc = spot[0] ? POS_NEAR : POS_MID;
    up = spot[1] ? POS_MID : (q_head.row_one ? POS_NEAR : POS_FAR);
    dn = spot[1] ? POS_MID : POS_NEAR;
    lf = spot[0] ? POS_MID : (q_head.col_one ? POS_NEAR : POS_FAR);
    rt = spot[0] ? POS_MID : POS_NEAR;
    odd_r = spot[1] ? q_head.row[0] : !q_head.row[0];
    odd_c = spot[0] ? q_head.col[0] : !q_head.col[0];
  end

  // Gather neighbors and sums
  always_comb begin
    ctr  = q_head.win[rc][cc];
    hl   = q_head.win[rc][lf];
    hr   = q_head.win[rc][rt];
    vu   = q_head.win[up][cc];
    vd   = q_head.win[dn][cc];
    d_ul = q_head.win[up][lf];
    d_ur = q_head.win[up][rt];
    d_dl = q_head.win[dn][lf];
    d_dr = q_head.win[dn][rt];
    hor  = (PIX_W + 1)'(hl) + (PIX_W + 1)'(hr);
    ver  = (PIX_W + 1)'(vu) + (PIX_W + 1)'(vd);
    dia  = (PIX_W + 2)'(d_ul) + (PIX_W + 2)'(d_ur) + (PIX_W + 2)'(d_dl)
         + (PIX_W + 2)'(d_dr);
    hv   = (PIX_W + 2)'(hor) + (PIX_W + 2)'(ver);
  end

  // Interpolate by Bayer phase: G at even/even and odd/odd, R at even/odd
  always_comb begin
    unique case ({odd_r, odd_c})
      2'b00: begin
        grn = ctr;
        red = hor[PIX_W:1];
        blu = ver[PIX_W:1];
      end
      2'b01: begin
        red = ctr;
        grn = hv[PIX_W+1:2];
        blu = dia[PIX_W+1:2];
      end
      2'b10: begin
        blu = ctr;
        grn = hv[PIX_W+1:2];
        red = dia[PIX_W+1:2];
      end
      2'b11: begin
        grn = ctr;
        red = ver[PIX_W:1];
        blu = hor[PIX_W:1];
      end
    endcase
  end

  // Interpolation stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else if (issue) begin
      b1_valid <= 1'b1;
    end else if (out_load) begin
      b1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      b1_r    <= red;
      b1_g    <= grn;
      b1_b    <= blu;
      b1_row  <= spot[1] ? q_head.row : q_head.row - 1'b1;
      b1_col  <= spot[0] ? q_head.col : q_head.col - 1'b1;
      b1_last <= last;
      b1_end  <= (spot == SPOT_LAST_ROW_LAST_COL);
    end
  end

  // Gray value
  assign gray_sum  = SUM_W'(b1_r) + SUM_W'(b1_g) + SUM_W'(b1_b);
  assign gray_prod = PROD_W'(gray_sum) * PROD_W'(GRAY_RECIP);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (cfg.gray_mode) begin
        out_first  <= gray_prod[GRAY_SHIFT +: PIX_W];
        out_second <= '0;
        out_third  <= '0;
      end else begin
        out_first  <= cfg.blue_first ? b1_b : b1_r;
        out_second <= b1_g;
        out_third  <= cfg.blue_first ? b1_r : b1_b;
      end
      out_row  <= b1_row;
      out_col  <= b1_col;
      out_last <= b1_last;
      out_end  <= b1_end;
    end
  end

  assign result.valid        = out_valid;
  assign result.first_byte   = out_first;
  assign result.second_byte  = out_second;
  assign result.third_byte   = out_third;
  assign result.pixel_row    = out_row;
  assign result.pixel_column = out_col;
  assign result.last_in_run  = out_last;
  assign result.frame_end    = out_end;

  // The frame corner is always the final pixel of its request
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.frame_end |-> result.last_in_run)
    else $error("frame end not last of its request");

  // A queued job always has a spot left to serve
  a_spot_pending: assert property (@(posedge clk) disable iff (rst)
    !q_empty |-> (remaining != '0))
    else $error("head job has no pending spot");

endmodule

### rtl/bayer_bilinear_demosaic_unit.sv
// Bilinear GRBG Bayer demosaic: APB registers, front end, job FIFO, back end.
// A request's first result passes the stage-1, job FIFO, interpolation and output
// stages. One sample per cycle in while the FIFO has room; one result per cycle
// out while the sink is ready; a row-end or last-row sample holds the back end.
// Reset (rst, synchronous): registers to defaults, position, window and FIFO
// cleared; line stores not cleared (rows are written before use).
module bayer_bilinear_demosaic_unit #(
  parameter int MAX_COLS = bbd_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = bbd_pkg::MAX_ROWS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  bbd_pixel_if.sink                        sample,
  bbd_result_if.source                     result,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bbd_pkg::PADDR_W-1:0]      paddr,
  input  logic [bbd_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [bbd_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import bbd_pkg::*;

  cfg_t                 cfg;
  logic                 cfg_write, restart;
  logic [REG_IDX_W-1:0] reg_idx;

  logic q_push, q_full, q_pop, q_empty;
  job_t q_job, q_head;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[PADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;
  assign restart   = cfg_write &&
                     (reg_idx == REG_FRAME_WIDTH || reg_idx == REG_FRAME_HEIGHT);

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width  <= WIDTH_RESET;
      cfg.frame_height <= HEIGHT_RESET;
      cfg.gray_mode    <= GRAY_RESET;
      cfg.blue_first   <= BLUE_RESET;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_FRAME_WIDTH:  cfg.frame_width  <= pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT: cfg.frame_height <= pwdata[DIM_W-1:0];
        REG_GRAY_MODE:    cfg.gray_mode    <= pwdata[0];
        REG_BLUE_FIRST:   cfg.blue_first   <= pwdata[0];
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (reg_idx)
      REG_FRAME_WIDTH:  prdata = APB_DATA_W'(cfg.frame_width);
      REG_FRAME_HEIGHT: prdata = APB_DATA_W'(cfg.frame_height);
      REG_GRAY_MODE:    prdata = APB_DATA_W'(cfg.gray_mode);
      REG_BLUE_FIRST:   prdata = APB_DATA_W'(cfg.blue_first);
    endcase
  end

  bbd_front #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .restart (restart),
    .sample  (sample),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_job   (q_job)
  );

  bbd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  bbd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .result  (result)
  );

endmodule

### test/bayer_bilinear_demosaic_unit_tb.sv
// Self-checking testbench for the bilinear GRBG demosaic unit.
// Drives raw samples and APB register writes, predicts every RGB/gray pixel.
// Depends on bbd_pkg, bbd_pixel_if, bbd_result_if and the unit itself.
`timescale 1ns / 100ps

module bayer_bilinear_demosaic_unit_tb;
  import bbd_pkg::*;

  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_PERCENT  = 12;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    pix_t               first_byte;
    pix_t               second_byte;
    pix_t               third_byte;
    logic [COORD_W-1:0] pixel_row;
    logic [COORD_W-1:0] pixel_column;
    logic               last_in_run;
    logic               frame_end;
  } shaded_pixel_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_W-1:0]    paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  bbd_pixel_if  sample_ch();
  bbd_result_if result_ch();

  bayer_bilinear_demosaic_unit dut (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the demosaic state
  cfg_t        mosaic_cfg;
  pix_t        older_row_mem [MAX_COLS_DEF];
  pix_t        newer_row_mem [MAX_COLS_DEF];
  pix_t        nbhd [3][3];
  int unsigned next_row;
  int unsigned next_col;

  shaded_pixel_t pending_pixels[$];

  int unsigned pixel_errors;
  int unsigned pixels_checked;
  int unsigned samples_fed;
  int unsigned geometries_used;
  int unsigned quiet_cycles;
  bit          src_idle_on;
  bit          sink_stall_on;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Error bookkeeping: print the first few, count the rest
  task automatic flag_error(input string what);
    pixel_errors++;
    if (pixel_errors <= REPORT_LIMIT) begin
      $display("ERROR @%0t: %s", $time, what);
    end
  endtask

  function automatic string describe_pixel(input shaded_pixel_t px);
    return $sformatf("(%0d,%0d) bytes %02h %02h %02h last %0b end %0b",
                     px.pixel_row, px.pixel_column, px.first_byte, px.second_byte,
                     px.third_byte, px.last_in_run, px.frame_end);
  endfunction

  function automatic int unsigned clamp_span(input logic [DIM_W-1:0] v,
                                             input int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void restart_frame();
    next_row = 0;
    next_col = 0;
    nbhd = '{default: '0};
  endfunction

  function automatic void model_reset();
    mosaic_cfg = '{frame_width: WIDTH_RESET, frame_height: HEIGHT_RESET,
                   gray_mode: GRAY_RESET, blue_first: BLUE_RESET};
    foreach (older_row_mem[i]) begin
      older_row_mem[i] = '0;
      newer_row_mem[i] = '0;
    end
    restart_frame();
  endfunction

  // Interpolate the pixel centered at nbhd[rc][cc], mirroring at the edges
  function automatic shaded_pixel_t shade_pixel(input int unsigned row, input int unsigned col,
                                                input int rc, input int cc,
                                                input int unsigned w, input int unsigned h);
    int            up, dn, lf, rt;
    int unsigned   ctr, hor, ver, dia, red, grn, blu;
    shaded_pixel_t px;
    up  = (row == 0) ? rc + 1 : rc - 1;
    dn  = (rc == 1) ? 2 : 1;
    lf  = (col == 0) ? cc + 1 : cc - 1;
    rt  = (cc == 1) ? 2 : 1;
    ctr = int'(nbhd[rc][cc]);
    hor = int'(nbhd[rc][lf]) + int'(nbhd[rc][rt]);
    ver = int'(nbhd[up][cc]) + int'(nbhd[dn][cc]);
    dia = int'(nbhd[up][lf]) + int'(nbhd[up][rt]) + int'(nbhd[dn][lf]) + int'(nbhd[dn][rt]);
    // GRBG: even/even G, even/odd R, odd/even B, odd/odd G
    if (row[0] == 1'b0 && col[0] == 1'b0) begin
      grn = ctr; red = hor / 2; blu = ver / 2;
    end else if (row[0] == 1'b0) begin
      red = ctr; grn = (hor + ver) / 4; blu = dia / 4;
    end else if (col[0] == 1'b0) begin
      blu = ctr; grn = (hor + ver) / 4; red = dia / 4;
    end else begin
      grn = ctr; red = ver / 2; blu = hor / 2;
    end
    if (mosaic_cfg.gray_mode) begin
      px.first_byte  = PIX_W'((red + grn + blu) / 3);
      px.second_byte = '0;
      px.third_byte  = '0;
    end else begin
      px.first_byte  = PIX_W'(mosaic_cfg.blue_first ? blu : red);
      px.second_byte = PIX_W'(grn);
      px.third_byte  = PIX_W'(mosaic_cfg.blue_first ? red : blu);
    end
    px.pixel_row    = COORD_W'(row);
    px.pixel_column = COORD_W'(col);
    px.last_in_run  = 1'b0;
    px.frame_end    = (row == h - 1) && (col == w - 1);
    return px;
  endfunction

  // Advance the shadow by one accepted sample and queue the pixels it completes
  function automatic void absorb_sample(input pix_t raw);
    int unsigned   w, h, r, c;
    shaded_pixel_t outs[$];
    w = clamp_span(mosaic_cfg.frame_width, MAX_COLS_DEF);
    h = clamp_span(mosaic_cfg.frame_height, MAX_ROWS_DEF);
    r = next_row;
    c = next_col;
    if (c >= w) c = w - 1;
    for (int i = 0; i < 3; i++) begin
      nbhd[i][0] = nbhd[i][1];
      nbhd[i][1] = nbhd[i][2];
    end
    nbhd[0][2] = older_row_mem[c];
    nbhd[1][2] = newer_row_mem[c];
    nbhd[2][2] = raw;
    older_row_mem[c] = newer_row_mem[c];
    newer_row_mem[c] = raw;
    if (r >= 1) begin
      if (c >= 1) outs.push_back(shade_pixel(r - 1, c - 1, 1, 1, w, h));
      if (c == w - 1) outs.push_back(shade_pixel(r - 1, c, 1, 2, w, h));
    end
    if (r == h - 1) begin
      if (c >= 1) outs.push_back(shade_pixel(r, c - 1, 2, 1, w, h));
      if (c == w - 1) outs.push_back(shade_pixel(r, c, 2, 2, w, h));
    end
    if (outs.size() > 0) outs[outs.size() - 1].last_in_run = 1'b1;
    foreach (outs[i]) pending_pixels.push_back(outs[i]);
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    next_row = r;
    next_col = c;
  endfunction

  function automatic logic [APB_DATA_W-1:0] reg_shadow(input logic [REG_IDX_W-1:0] idx);
    case (idx)
      REG_FRAME_WIDTH:  return APB_DATA_W'(mosaic_cfg.frame_width);
      REG_FRAME_HEIGHT: return APB_DATA_W'(mosaic_cfg.frame_height);
      REG_GRAY_MODE:    return APB_DATA_W'(mosaic_cfg.gray_mode);
      default:          return APB_DATA_W'(mosaic_cfg.blue_first);
    endcase
  endfunction

  // APB write: setup, access, then drop the select
  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    @(posedge clk);
    case (idx)
      REG_FRAME_WIDTH: begin
        mosaic_cfg.frame_width = value[DIM_W-1:0];
        restart_frame();
      end
      REG_FRAME_HEIGHT: begin
        mosaic_cfg.frame_height = value[DIM_W-1:0];
        restart_frame();
      end
      REG_GRAY_MODE:  mosaic_cfg.gray_mode  = value[0];
      REG_BLUE_FIRST: mosaic_cfg.blue_first = value[0];
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // APB read, compared against the shadow register
  task automatic reg_check(input logic [REG_IDX_W-1:0] idx);
    logic [APB_DATA_W-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    got = prdata;
    @(posedge clk);
    if (got !== reg_shadow(idx)) begin
      flag_error($sformatf("register %0d read %h, expected %h", idx, got, reg_shadow(idx)));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_geometry(input int unsigned w, input int unsigned h);
    reg_write(REG_FRAME_WIDTH, ($urandom() & 32'hFFFF_F800) | APB_DATA_W'(w));
    reg_write(REG_FRAME_HEIGHT, ($urandom() & 32'hFFFF_F800) | APB_DATA_W'(h));
    geometries_used++;
  endtask

  task automatic set_mode(input bit gray, input bit blue);
    reg_write(REG_GRAY_MODE, ($urandom() & ~32'h1) | APB_DATA_W'(gray));
    reg_write(REG_BLUE_FIRST, ($urandom() & ~32'h1) | APB_DATA_W'(blue));
  endtask

  // Send one raw sample; returns at the edge that accepts it
  task automatic send_sample(input pix_t raw);
    int gap;
    if (src_idle_on && $urandom_range(199) < IDLE_PERCENT) begin
      gap = $urandom_range(3, 1);
      sample_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_ch.valid     <= 1'b1;
    sample_ch.raw_pixel <= raw;
    @(negedge clk);
    while (!sample_ch.ready) @(negedge clk);
    absorb_sample(raw);
    samples_fed++;
    @(posedge clk);
  endtask

  // Hold the sender until every queued pixel is out, then let the pipe settle
  task automatic drain_pixels();
    sample_ch.valid <= 1'b0;
    while (pending_pixels.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic pix_t random_pixel();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  task automatic send_random(input int unsigned count);
    repeat (count) send_sample(random_pixel());
  endtask

  // Defaults after reset, then every register written and read back
  task automatic test_register_access();
    for (int i = 0; i < 4; i++) reg_check(REG_IDX_W'(i));
    reg_write(REG_FRAME_WIDTH, 32'hFFFF_FFFF);
    reg_write(REG_FRAME_HEIGHT, 32'h0000_0000);
    reg_write(REG_GRAY_MODE, 32'h0000_0001);
    reg_write(REG_BLUE_FIRST, 32'hFFFF_FFFE);
    for (int i = 0; i < 4; i++) reg_check(REG_IDX_W'(i));
    reg_write(REG_FRAME_WIDTH, 32'd1024);
    reg_write(REG_FRAME_HEIGHT, 32'd2);
    reg_write(REG_GRAY_MODE, 32'h0000_0000);
    reg_write(REG_BLUE_FIRST, 32'h0000_0001);
    for (int i = 0; i < 4; i++) reg_check(REG_IDX_W'(i));
  endtask

  // 4x4 frame in RGB order with full-scale and ramp samples to stress the mirror edges
  task automatic test_colour_window();
    set_mode(1'b0, 1'b0);
    set_geometry(4, 4);
    for (int i = 0; i < 16; i++) begin
      case (i % 3)
        0:       send_sample(8'hFF);
        1:       send_sample(8'h00);
        default: send_sample(PIX_W'(i * 17));
      endcase
    end
    drain_pixels();
  endtask

  // Degenerate sizes clamp to 2x2; gray of saturated samples must stay 255
  task automatic test_gray_tiny_frame();
    set_mode(1'b1, 1'b1);
    reg_write(REG_FRAME_WIDTH, 32'd1);
    reg_write(REG_FRAME_HEIGHT, 32'd0);
    repeat (4) send_sample(8'hFF);
    drain_pixels();
  endtask

  task automatic test_odd_geometry();
    set_mode(1'b0, 1'b1);
    set_geometry(5, 3);
    send_random(30);
    drain_pixels();
    set_mode(1'b1, 1'b0);
    set_geometry(3, 5);
    send_random(15);
    drain_pixels();
  endtask

  // Oversized width and height clamp to the maximum; run the first rows of each
  task automatic test_wide_and_tall();
    set_mode(1'b0, 1'b1);
    set_geometry(2047, 2);
    send_random(24);
    drain_pixels();
    set_mode(1'b1, 1'b0);
    set_geometry(2, 2047);
    send_random(24);
    drain_pixels();
  endtask

  // Abandon a frame half way, restart it, and pause mid-frame until the pipe is empty
  task automatic test_restart_midframe();
    set_mode(1'b0, 1'b0);
    set_geometry(6, 4);
    send_random(13);
    drain_pixels();
    reg_write(REG_FRAME_HEIGHT, 32'd4);
    send_random(11);
    drain_pixels();
    send_random(13);
    drain_pixels();
  endtask

  // Random geometries and modes, mostly whole frames, some cut short
  task automatic test_random_frames();
    int unsigned fed, w, h, span, count, seg;
    fed = 0;
    seg = 0;
    while (fed < 100) begin
      w = ($urandom_range(3) == 0) ? $urandom_range(12, 2) : 2 * $urandom_range(6, 1);
      h = ($urandom_range(3) == 0) ? $urandom_range(7, 2) : 2 * $urandom_range(3, 1);
      // the first segment runs back to back with no idling on either side
      src_idle_on   = (seg != 0);
      sink_stall_on = (seg != 0);
      set_mode($urandom_range(1), $urandom_range(1));
      set_geometry(w, h);
      span = w * h;
      if (seg == 0) count = 2 * span;
      else if ($urandom_range(4) == 0) count = $urandom_range(span - 1, 1);
      else count = span * $urandom_range(2, 1);
      send_random(count);
      fed += count;
      drain_pixels();
      seg++;
    end
    src_idle_on   = 1'b1;
    sink_stall_on = 1'b1;
  endtask

  // Result sink: stall at random while stalls are enabled
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (!sink_stall_on) begin
      result_ch.ready <= 1'b1;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Compare each accepted pixel with the oldest prediction; sampled mid-cycle
  always @(negedge clk) begin : check_results
    shaded_pixel_t got, want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.first_byte   = result_ch.first_byte;
      got.second_byte  = result_ch.second_byte;
      got.third_byte   = result_ch.third_byte;
      got.pixel_row    = result_ch.pixel_row;
      got.pixel_column = result_ch.pixel_column;
      got.last_in_run  = result_ch.last_in_run;
      got.frame_end    = result_ch.frame_end;
      if (pending_pixels.size() == 0) begin
        flag_error($sformatf("unexpected pixel %s", describe_pixel(got)));
      end else begin
        want = pending_pixels.pop_front();
        pixels_checked++;
        if (got !== want) begin
          flag_error($sformatf("expected %s, got %s", describe_pixel(want),
                               describe_pixel(got)));
        end
      end
    end
  end

  // Watchdog: give up when no request moves on any port for too long
  always @(negedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((sample_ch.valid && sample_ch.ready) ||
                 (result_ch.valid && result_ch.ready) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no activity for %0d cycles, %0d pixels outstanding",
               QUIET_LIMIT, pending_pixels.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst                 = 1'b1;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    sample_ch.valid     = 1'b0;
    sample_ch.raw_pixel = '0;
    result_ch.ready     = 1'b0;
    src_idle_on         = 1'b1;
    sink_stall_on       = 1'b1;
    pixel_errors        = 0;
    pixels_checked      = 0;
    samples_fed         = 0;
    geometries_used     = 0;
    model_reset();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_register_access();
    test_colour_window();
    test_gray_tiny_frame();
    test_odd_geometry();
    test_restart_midframe();
    test_wide_and_tall();
    test_random_frames();
    drain_pixels();

    $display("Fed %0d raw samples over %0d frame geometries, checked %0d pixels",
             samples_fed, geometries_used, pixels_checked);
    $display("Covered colour and gray modes, both channel orders, clamped and odd sizes");
    if (pixel_errors == 0 && pending_pixels.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d errors, %0d pixels never arrived", pixel_errors, pending_pixels.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
